// ----- sv/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and phase tables shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   // Opcodes carried by a request transaction
   localparam logic [2:0] OPC_TICK  = 3'd0;
   localparam logic [2:0] OPC_START = 3'd1;
   localparam logic [2:0] OPC_STOP  = 3'd2;
   localparam logic [2:0] OPC_WRITE = 3'd3;
   localparam logic [2:0] OPC_READ  = 3'd4;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam logic [7:0]  MSB_MASK      = 8'h80;

   // Phase bounds of each command
   localparam logic [4:0] WR_BIT_PHASES = 5'(3 * BITS_PER_BYTE);
   localparam logic [4:0] WR_ACK_SAMPLE = 5'(3 * BITS_PER_BYTE + 1);
   localparam logic [4:0] WR_LAST       = 5'(3 * BITS_PER_BYTE + 2);
   localparam logic [4:0] RD_BIT_LAST   = 5'(2 * BITS_PER_BYTE);
   localparam logic [4:0] RD_ACK_DRIVE  = 5'(2 * BITS_PER_BYTE + 1);
   localparam logic [4:0] RD_ACK_HIGH   = 5'(2 * BITS_PER_BYTE + 2);
   localparam logic [4:0] RD_ACK_LOW    = 5'(2 * BITS_PER_BYTE + 3);
   localparam logic [4:0] RD_LAST       = 5'(2 * BITS_PER_BYTE + 4);
   localparam logic [4:0] BASIC_LAST    = 5'd3;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd8;

   // Running command, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_STOP  = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_READ  = 5'b10000
   } cmd_state_type;

   // Pin action taken on the first tick of a phase
   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_SCL_LOW = 3'd1,
      ACT_SCL_REL = 3'd2,
      ACT_SDA_LOW = 3'd3,
      ACT_SDA_REL = 3'd4
   } act_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
   } rsp_type;

   // Phase modulo 3 by reciprocal: floor(p/3) == (p*11)>>5 for any 5-bit p
   function automatic logic [1:0] phase_mod3(input logic [4:0] p);
      logic [8:0] prod;
      logic [3:0] quo;
      logic [4:0] rem;
      prod = {4'b0, p} * 9'd11;
      quo  = prod[8:5];
      rem  = p - 5'({1'b0, quo} * 5'd3);
      return rem[1:0];
   endfunction

   function automatic logic [4:0] last_phase(input cmd_state_type cmd);
      logic [4:0] lp;
      lp = BASIC_LAST;
      if (cmd == ST_WRITE) lp = WR_LAST;
      if (cmd == ST_READ)  lp = RD_LAST;
      return lp;
   endfunction

   function automatic act_type phase_action(input cmd_state_type cmd,
                                            input logic [4:0]    p,
                                            input logic          msb,
                                            input logic          ack_sel);
      act_type act;
      act = ACT_NONE;
      unique case (cmd)
         ST_START: begin
            case (p[1:0])
               2'd0:    act = ACT_SDA_REL;
               2'd1:    act = ACT_SCL_REL;
               2'd2:    act = ACT_SDA_LOW;
               default: act = ACT_SCL_LOW;
            endcase
         end
         ST_STOP: begin
            case (p[1:0])
               2'd0:    act = ACT_SDA_LOW;
               2'd1:    act = ACT_SCL_REL;
               2'd2:    act = ACT_SDA_REL;
               default: act = ACT_NONE;
            endcase
         end
         ST_WRITE: begin
            if (p < WR_BIT_PHASES) begin
               case (phase_mod3(p))
                  2'd0:    act = msb ? ACT_SDA_REL : ACT_SDA_LOW;
                  2'd1:    act = ACT_SCL_REL;
                  default: act = ACT_SCL_LOW;
               endcase
            end else if (p == WR_BIT_PHASES) begin
               act = ACT_SDA_REL;
            end else if (p == WR_ACK_SAMPLE) begin
               act = ACT_SCL_REL;
            end else begin
               act = ACT_SCL_LOW;
            end
         end
         ST_READ: begin
            if (p == 5'd0) begin
               act = ACT_SDA_REL;
            end else if (p <= RD_BIT_LAST) begin
               act = p[0] ? ACT_SCL_REL : ACT_SCL_LOW;
            end else if (p == RD_ACK_DRIVE) begin
               act = ack_sel ? ACT_SDA_LOW : ACT_SDA_REL;
            end else if (p == RD_ACK_HIGH) begin
               act = ACT_SCL_REL;
            end else if (p == RD_ACK_LOW) begin
               act = ACT_SCL_LOW;
            end else begin
               act = ACT_SDA_REL;
            end
         end
         default: act = ACT_NONE;
      endcase
      return act;
   endfunction

   // SDA is sampled at the end of this phase
   function automatic logic phase_samples(input cmd_state_type cmd,
                                          input logic [4:0]    p);
      logic samp;
      samp = 1'b0;
      if (cmd == ST_WRITE) samp = (p == WR_ACK_SAMPLE);
      if (cmd == ST_READ)  samp = (p != 5'd0) && (p <= RD_BIT_LAST) && p[0];
      return samp;
   endfunction

endpackage

`default_nettype wire

// ----- sv/i2cm_req_stage.sv -----
// ----------------------------------------------------------------------------
// i2cm_req_stage
// Input register: captures one request transaction per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_req_stage
   import i2cm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    advance,
   output logic         stage_valid,
   output req_type      stage_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // Stall only while a held item cannot move on
   assign req_stall = valid_ff & ~advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         data_ff <= req_data;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

`default_nettype wire

// ----- sv/i2cm_step_core.sv -----
// ----------------------------------------------------------------------------
// i2cm_step_core
// Bus command state and the one-tick update of pins, counters and data.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_step_core
   import i2cm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  wire req_type     stage_data,
   input  wire logic        csr_write,
   input  wire logic [15:0] csr_data,
   output rsp_type          rsp_next
);

   cmd_state_type st_ff, st_in;
   logic [4:0]    phase_ff, phase_in;
   logic [15:0]   tick_ff, tick_in;
   logic [7:0]    shift_ff, shift_in;
   logic          ack_choice_ff, ack_choice_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in_nx;
   logic          ack_flag_ff, ack_flag_in;
   logic [7:0]    rx_ff, rx_in;
   logic [15:0]   phase_ticks_ff;

   cmd_state_type dec_cmd;
   act_type       act;
   logic          samp;
   logic          done;
   logic          phase_end;
   logic [15:0]   tick_next;
   logic [15:0]   limit;

   // Decode opcode; unused codes act as tick only
   always_comb begin
      unique case (stage_data.opcode)
         OPC_START: dec_cmd = ST_START;
         OPC_STOP:  dec_cmd = ST_STOP;
         OPC_WRITE: dec_cmd = ST_WRITE;
         OPC_READ:  dec_cmd = ST_READ;
         default:   dec_cmd = ST_IDLE;
      endcase
   end

   assign limit = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;

   // One tick of bus timing
   always_comb begin
      st_in         = st_ff;
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      shift_in      = shift_ff;
      ack_choice_in = ack_choice_ff;
      scl_in        = scl_ff;
      sda_in_nx     = sda_ff;
      ack_flag_in   = ack_flag_ff;
      rx_in         = rx_ff;
      done          = 1'b0;
      act           = ACT_NONE;
      samp          = 1'b0;
      phase_end     = 1'b0;
      tick_next     = 16'd0;

      // Start a command only when idle
      if (st_ff == ST_IDLE && dec_cmd != ST_IDLE) begin
         st_in    = dec_cmd;
         phase_in = 5'd0;
         tick_in  = 16'd0;
         if (dec_cmd == ST_WRITE) shift_in = stage_data.tx_byte;
         if (dec_cmd == ST_READ) begin
            shift_in      = 8'd0;
            ack_choice_in = stage_data.send_ack;
         end
      end

      if (st_in != ST_IDLE) begin
         act  = phase_action(st_in, phase_in, |(shift_in & MSB_MASK), ack_choice_in);
         samp = phase_samples(st_in, phase_in);
         case (act)
            ACT_SCL_LOW: scl_in    = 1'b1;
            ACT_SCL_REL: scl_in    = 1'b0;
            ACT_SDA_LOW: sda_in_nx = 1'b1;
            ACT_SDA_REL: sda_in_nx = 1'b0;
            default: ;
         endcase

         tick_next = tick_in + 16'd1;
         phase_end = (tick_next >= limit) || (tick_next == 16'd0);
         tick_in   = tick_next;

         if (phase_end) begin
            if (samp) begin
               if (st_in == ST_WRITE) ack_flag_in = ~stage_data.sda_in;
               else                   shift_in    = {shift_in[6:0], stage_data.sda_in};
            end
            // Move to next data bit after its SCL-low phase
            if (st_in == ST_WRITE && phase_in < WR_BIT_PHASES
                && phase_mod3(phase_in) == 2'd2) begin
               shift_in = {shift_in[6:0], 1'b0};
            end
            tick_in = 16'd0;
            if (phase_in >= last_phase(st_in)) begin
               if (st_in == ST_READ) rx_in = shift_in;
               st_in    = ST_IDLE;
               phase_in = 5'd0;
               done     = 1'b1;
            end else begin
               phase_in = phase_in + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         phase_ff      <= 5'd0;
         tick_ff       <= 16'd0;
         shift_ff      <= 8'd0;
         ack_choice_ff <= 1'b0;
         scl_ff        <= 1'b0;
         sda_ff        <= 1'b0;
         ack_flag_ff   <= 1'b0;
         rx_ff         <= 8'd0;
      end else if (fire) begin
         st_ff         <= st_in;
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         shift_ff      <= shift_in;
         ack_choice_ff <= ack_choice_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in_nx;
         ack_flag_ff   <= ack_flag_in;
         rx_ff         <= rx_in;
      end
   end

   // Phase length register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else if (csr_write) begin
         phase_ticks_ff <= csr_data;
      end
   end

   assign rsp_next.scl_drive_low = scl_in;
   assign rsp_next.sda_drive_low = sda_in_nx;
   assign rsp_next.busy_res      = (st_in != ST_IDLE);
   assign rsp_next.done_res      = done;
   assign rsp_next.rx_byte       = rx_in;
   assign rsp_next.ack_seen      = ack_flag_in;

endmodule

`default_nettype wire

// ----- sv/i2cm_rsp_stage.sv -----
// ----------------------------------------------------------------------------
// i2cm_rsp_stage
// Result register: holds one response transaction until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_rsp_stage
   import i2cm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    stage_valid,
   input  wire rsp_type rsp_next,
   output logic         advance,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   // Move on when the register is empty or being drained
   assign advance = ~valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage_valid) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ----- sv/i2c_master_byte_engine.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master running START, STOP, byte write and byte read,
// one bus tick per request transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | req_type: opcode, tx_byte, send_ack, sda_in
//  rsp_    | out       | rsp_valid/rsp_stall  | rsp_type: pins, busy, done, rx_byte, ack
//  csr_    | in        | csr_valid/csr_ready  | csr_data: phase_ticks (16 bit)
//
//  One transaction per cycle sustained while rsp_stall is low; a tick's result
//  passes through the input register, then one update pass into the result
//  register, and is held there on rsp_ until it is taken.
//  Synchronous active-high reset clears state; phase_ticks returns to 8.
//  rsp_stall holds the result register and, once the input register is full,
//  raises req_stall in the same cycle. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine
   import i2cm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   logic    advance;
   logic    stage_valid;
   req_type stage_data;
   rsp_type rsp_next;

   assign csr_ready = 1'b1;

   i2cm_req_stage u_req (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .stage_valid(stage_valid),
      .stage_data (stage_data)
   );

   i2cm_step_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (stage_valid & advance),
      .stage_data(stage_data),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .rsp_next  (rsp_next)
   );

   i2cm_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .stage_valid(stage_valid),
      .rsp_next   (rsp_next),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- sv/i2cm_checker.sv -----
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker
   import i2cm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire rsp_type     rsp_data
);

   // A stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Input side backs up only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output back-pressure");

   // A completing command leaves the engine idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done reported while still busy");

   // Nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid directly after reset");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);

`default_nettype wire
